FILE: sv/igt_pkg.sv
package igt_pkg;

    // frame store geometry and pixel width
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PIXEL_BITS = 32;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // fixed field widths
    localparam int COORD_W = 8;
    localparam int CFG_W   = 9;
    localparam int MODE_W  = 3;
    localparam int CIDX_W  = 3;
    localparam int OUT_W   = 32;

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // transform modes
    localparam logic [MODE_W-1:0] MODE_RESIZE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CROP   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FLIP_H = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLIP_V = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROT_CW = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ROT_CC = 3'd5;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CIDX_W-1:0] REG_SRC_WIDTH  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_SRC_HEIGHT = 3'd2;
    localparam logic [CIDX_W-1:0] REG_OUT_WIDTH  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_OUT_HEIGHT = 3'd4;
    localparam logic [CIDX_W-1:0] REG_CROP_X     = 3'd5;
    localparam logic [CIDX_W-1:0] REG_CROP_Y     = 3'd6;

endpackage

FILE: sv/image_geometric_transform_core.sv
// Geometric transform core: a frame store with nearest-neighbour resize, crop,
// flips and 90-degree rotations on read.
// Command channel: a transfer happens at a clock edge with start high and busy
// low. A load (opcode 0) writes i_pixel_in into the store at that edge, gives
// no result and leaves busy low, so loads may follow every cycle. A read
// (opcode 1) raises busy until its result has been produced.
// Result channel: o_valid is high for exactly one cycle with o_pixel_out,
// o_zero_filled and o_coord_error; the receiver cannot hold it off.
// A read with a coordinate error, or a crop source outside the frame, skips the
// store and goes straight to the result; crop, flip and rotate go to the store
// read; resize first maps the source through one shared 9-step restoring
// divider run twice (column, then row), each pass preceded by a multiply step;
// the divider sets the resize rate. The store read adds an address state and a
// registered read state. Configuration writes take effect at once; the user
// must make them only while busy is low, as the block does not enforce it.
// Reset (synchronous, active low) restores the register defaults and idles
// the sequencer; the frame store keeps no reset and must be loaded before use.
module image_geometric_transform_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [igt_pkg::COORD_W-1:0]   i_coord_x,
    input  logic [igt_pkg::COORD_W-1:0]   i_coord_y,
    input  logic [31:0]                   i_pixel_in,
    input  logic                          i_cfg_we,
    input  logic [igt_pkg::CIDX_W-1:0]    i_cfg_addr,
    input  logic [igt_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                          o_valid,
    output logic [igt_pkg::OUT_W-1:0]     o_pixel_out,
    output logic                          o_zero_filled,
    output logic                          o_coord_error
);

    localparam int QW     = igt_pkg::CFG_W;
    localparam int CW     = igt_pkg::COORD_W;
    localparam int PW     = CW + QW;
    localparam int CNT_W  = $clog2(QW);
    localparam int AW     = igt_pkg::ADDR_W;
    localparam int PB     = igt_pkg::PIXEL_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_ADDR,
        S_MEM,
        S_OUT
    } t_state;

    function automatic logic [QW-1:0] clamp_dim(input logic [QW-1:0] v, input int maxv);
        logic [QW-1:0] res;
        if (v == '0) begin
            res = QW'(1);
        end else if (32'(v) > maxv) begin
            res = QW'(maxv);
        end else begin
            res = v;
        end
        return res;
    endfunction

    t_state                       r_state;
    logic [igt_pkg::MODE_W-1:0]   r_mode;
    logic [QW-1:0]                r_src_w;
    logic [QW-1:0]                r_src_h;
    logic [QW-1:0]                r_out_w;
    logic [QW-1:0]                r_out_h;
    logic [QW-1:0]                r_crop_x;
    logic [QW-1:0]                r_crop_y;

    logic [CW-1:0]                r_x;
    logic [CW-1:0]                r_y;
    logic [QW-1:0]                r_sx;
    logic [QW-1:0]                r_sy;
    logic                         r_ok;
    logic                         r_axis;
    logic [QW-1:0]                r_rem;
    logic [QW-1:0]                r_quo;
    logic [QW-1:0]                r_den;
    logic [CNT_W-1:0]             r_cnt;
    logic [AW-1:0]                r_addr;

    logic                         r_valid;
    logic [igt_pkg::OUT_W-1:0]    r_pix;
    logic                         r_filled;
    logic                         r_err;

    logic [PB-1:0]                r_mem [igt_pkg::STORE_DEPTH];
    logic [PB-1:0]                r_rdata;

    logic [QW-1:0]                sw;
    logic [QW-1:0]                sh;
    logic [QW-1:0]                ow;
    logic [QW-1:0]                oh;
    logic                         coord_err;
    logic                         crop_out;
    logic [QW-1:0]                map_sx;
    logic [QW-1:0]                map_sy;
    logic signed [QW:0]           crop_cx;
    logic signed [QW:0]           crop_cy;
    logic [PW-1:0]                n_prod;
    logic [QW:0]                  div_trial;
    logic                         div_ge;
    logic [QW-1:0]                n_rem;
    logic [QW-1:0]                n_quo;
    logic [QW-1:0]                div_dim;
    logic [QW-1:0]                n_coord;
    logic                         accept;
    logic                         load_we;
    logic [AW-1:0]                load_addr;

    assign accept    = start && (r_state == S_IDLE);
    assign load_we   = accept && (i_opcode == igt_pkg::OP_LOAD)
                       && (32'(i_coord_x) < igt_pkg::MAX_WIDTH)
                       && (32'(i_coord_y) < igt_pkg::MAX_HEIGHT);
    assign load_addr = AW'(32'(i_coord_y) * igt_pkg::MAX_WIDTH + 32'(i_coord_x));

    assign sw = clamp_dim(r_src_w, igt_pkg::MAX_WIDTH);
    assign sh = clamp_dim(r_src_h, igt_pkg::MAX_HEIGHT);

    // output size and direct coordinate mapping for the latched request
    always_comb begin
        ow = '0;
        oh = '0;
        unique case (r_mode) inside
            igt_pkg::MODE_RESIZE, igt_pkg::MODE_CROP: begin
                ow = r_out_w;
                oh = r_out_h;
            end
            igt_pkg::MODE_FLIP_H, igt_pkg::MODE_FLIP_V: begin
                ow = sw;
                oh = sh;
            end
            igt_pkg::MODE_ROT_CW, igt_pkg::MODE_ROT_CC: begin
                ow = sh;
                oh = sw;
            end
            default: begin
                ow = '0;
                oh = '0;
            end
        endcase
    end

    assign coord_err = ({1'b0, r_x} >= ow) || ({1'b0, r_y} >= oh);

    assign crop_cx = signed'({2'b00, r_x}) + signed'({r_crop_x[QW-1], r_crop_x});
    assign crop_cy = signed'({2'b00, r_y}) + signed'({r_crop_y[QW-1], r_crop_y});

    always_comb begin
        map_sx   = '0;
        map_sy   = '0;
        crop_out = 1'b0;
        unique case (r_mode) inside
            igt_pkg::MODE_CROP: begin
                crop_out = (crop_cx < 0) || (crop_cy < 0)
                           || (crop_cx >= signed'({1'b0, sw}))
                           || (crop_cy >= signed'({1'b0, sh}));
                map_sx = crop_cx[QW-1:0];
                map_sy = crop_cy[QW-1:0];
            end
            igt_pkg::MODE_FLIP_H: begin
                map_sx = sw - QW'(1) - QW'(r_x);
                map_sy = QW'(r_y);
            end
            igt_pkg::MODE_FLIP_V: begin
                map_sx = QW'(r_x);
                map_sy = sh - QW'(1) - QW'(r_y);
            end
            igt_pkg::MODE_ROT_CW: begin
                map_sx = QW'(r_y);
                map_sy = sh - QW'(1) - QW'(r_x);
            end
            igt_pkg::MODE_ROT_CC: begin
                map_sx = sw - QW'(1) - QW'(r_y);
                map_sy = QW'(r_x);
            end
            default: begin
                map_sx   = '0;
                map_sy   = '0;
                crop_out = 1'b0;
            end
        endcase
    end

    // shared unit: coord * src_dim, then one restoring quotient bit per cycle
    assign n_prod    = r_axis ? (PW'(r_y) * PW'(sh)) : (PW'(r_x) * PW'(sw));
    assign div_trial = {r_rem, r_quo[QW-1]};
    assign div_ge    = div_trial >= {1'b0, r_den};
    assign n_rem     = div_ge ? QW'(div_trial - {1'b0, r_den}) : div_trial[QW-1:0];
    assign n_quo     = {r_quo[QW-2:0], div_ge};
    assign div_dim   = r_axis ? sh : sw;
    assign n_coord   = (n_quo >= div_dim) ? (div_dim - QW'(1)) : n_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_mode   <= igt_pkg::MODE_RESIZE;
            r_src_w  <= QW'(256);
            r_src_h  <= QW'(256);
            r_out_w  <= QW'(256);
            r_out_h  <= QW'(256);
            r_crop_x <= '0;
            r_crop_y <= '0;
        end else begin
            r_valid <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    igt_pkg::REG_MODE:       r_mode   <= i_cfg_wdata[igt_pkg::MODE_W-1:0];
                    igt_pkg::REG_SRC_WIDTH:  r_src_w  <= i_cfg_wdata;
                    igt_pkg::REG_SRC_HEIGHT: r_src_h  <= i_cfg_wdata;
                    igt_pkg::REG_OUT_WIDTH:  r_out_w  <= i_cfg_wdata;
                    igt_pkg::REG_OUT_HEIGHT: r_out_h  <= i_cfg_wdata;
                    igt_pkg::REG_CROP_X:     r_crop_x <= i_cfg_wdata;
                    igt_pkg::REG_CROP_Y:     r_crop_y <= i_cfg_wdata;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_opcode == igt_pkg::OP_READ)) begin
                        r_x     <= i_coord_x;
                        r_y     <= i_coord_y;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_err    <= 1'b0;
                    r_filled <= 1'b0;
                    r_ok     <= 1'b1;
                    r_sx     <= map_sx;
                    r_sy     <= map_sy;
                    r_axis   <= 1'b0;
                    if (coord_err) begin
                        r_err   <= 1'b1;
                        r_ok    <= 1'b0;
                        r_state <= S_OUT;
                    end else if (r_mode == igt_pkg::MODE_RESIZE) begin
                        r_state <= S_MUL;
                    end else if (crop_out) begin
                        r_filled <= 1'b1;
                        r_ok     <= 1'b0;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_ADDR;
                    end
                end
                S_MUL: begin
                    // quotient stays below the source size, so the top bits
                    // already sit below the divisor
                    r_rem   <= QW'(n_prod[PW-1:QW]);
                    r_quo   <= n_prod[QW-1:0];
                    r_den   <= r_axis ? oh : ow;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(QW - 1)) begin
                        if (r_axis) begin
                            r_sy    <= n_coord;
                            r_state <= S_ADDR;
                        end else begin
                            r_sx    <= n_coord;
                            r_axis  <= 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_ADDR: begin
                    r_addr <= AW'(32'(r_sy) * igt_pkg::MAX_WIDTH + 32'(r_sx));
                    if (!((32'(r_sx) < igt_pkg::MAX_WIDTH)
                          && (32'(r_sy) < igt_pkg::MAX_HEIGHT))) begin
                        r_ok <= 1'b0;
                    end
                    r_state <= S_MEM;
                end
                S_MEM: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_pix   <= r_ok ? igt_pkg::OUT_W'(r_rdata) : '0;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // frame store: one write port for loads, one registered read port
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_mem[load_addr] <= PB'(i_pixel_in);
        end
        r_rdata <= r_mem[r_addr];
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_pixel_out   = r_pix;
    assign o_zero_filled = r_filled;
    assign o_coord_error = r_err;

endmodule

FILE: sv/igt_checker.sv
module igt_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          i_opcode,
    input  logic                          o_valid,
    input  logic [igt_pkg::OUT_W-1:0]     o_pixel_out,
    input  logic                          o_zero_filled,
    input  logic                          o_coord_error
);

    // a result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // a load transfer never makes the block busy
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == igt_pkg::OP_LOAD)) |=> !busy)
        else $error("busy after a load transfer");

    // a read transfer makes the block busy, with no result yet
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == igt_pkg::OP_READ)) |=> (busy && !o_valid))
        else $error("read transfer did not occupy the block");

    // the end of busy comes with the result strobe
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_valid)
        else $error("busy dropped without a result");

    // flagged results carry a zero pixel and only one flag
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_zero_filled || o_coord_error))
            |-> ((o_pixel_out == '0) && !(o_zero_filled && o_coord_error)))
        else $error("flagged result with pixel data or both flags");

endmodule

bind image_geometric_transform_core igt_checker u_igt_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int IDLE_PLAN [4] = '{0, 76, 0, 24};

    // mode codes the block leaves unused
    localparam logic [igt_pkg::MODE_W-1:0] MODE_UNUSED_A = 3'd6;
    localparam logic [igt_pkg::MODE_W-1:0] MODE_UNUSED_B = 3'd7;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic                         i_opcode;
    logic [igt_pkg::COORD_W-1:0]  i_coord_x;
    logic [igt_pkg::COORD_W-1:0]  i_coord_y;
    logic [31:0]                  i_pixel_in;
    logic                         i_cfg_we;
    logic [igt_pkg::CIDX_W-1:0]   i_cfg_addr;
    logic [igt_pkg::CFG_W-1:0]    i_cfg_wdata;
    logic                         o_valid;
    logic [igt_pkg::OUT_W-1:0]    o_pixel_out;
    logic                         o_zero_filled;
    logic                         o_coord_error;

    typedef struct {
        logic [igt_pkg::OUT_W-1:0] pix;
        logic                      zero_filled;
        logic                      coord_error;
    } t_pixel_result;

    class t_frame_checker;
        bit [igt_pkg::MODE_W-1:0] mode;
        bit [igt_pkg::CFG_W-1:0]  src_w, src_h, out_w, out_h, crop_x, crop_y;
        logic [31:0]              frame [int];
        t_pixel_result            expected_q [$];
        int                       errors;
        int                       checked;

        function new();
            mode   = igt_pkg::MODE_RESIZE;
            src_w  = 256;
            src_h  = 256;
            out_w  = 256;
            out_h  = 256;
            crop_x = '0;
            crop_y = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [igt_pkg::CIDX_W-1:0] idx,
                                logic [igt_pkg::CFG_W-1:0] val);
            case (idx)
                igt_pkg::REG_MODE:       mode   = val[igt_pkg::MODE_W-1:0];
                igt_pkg::REG_SRC_WIDTH:  src_w  = val;
                igt_pkg::REG_SRC_HEIGHT: src_h  = val;
                igt_pkg::REG_OUT_WIDTH:  out_w  = val;
                igt_pkg::REG_OUT_HEIGHT: out_h  = val;
                igt_pkg::REG_CROP_X:     crop_x = val;
                igt_pkg::REG_CROP_Y:     crop_y = val;
                default: ;
            endcase
        endfunction

        // returns 1 when the read takes a pixel from the frame store
        function bit map_source(input logic [igt_pkg::COORD_W-1:0] x,
                                input logic [igt_pkg::COORD_W-1:0] y,
                                output int addr, output bit filled, output bit err);
            int sw, sh, ow, oh, sx, sy, xi, yi, cx, cy;
            xi = int'(x);
            yi = int'(y);
            sw = (src_w == 0) ? 1 : ((int'(src_w) > igt_pkg::MAX_WIDTH) ?
                 igt_pkg::MAX_WIDTH : int'(src_w));
            sh = (src_h == 0) ? 1 : ((int'(src_h) > igt_pkg::MAX_HEIGHT) ?
                 igt_pkg::MAX_HEIGHT : int'(src_h));
            addr   = 0;
            filled = 1'b0;
            err    = 1'b0;
            sx     = 0;
            sy     = 0;
            case (mode)
                igt_pkg::MODE_RESIZE, igt_pkg::MODE_CROP: begin
                    ow = int'(out_w);
                    oh = int'(out_h);
                end
                igt_pkg::MODE_FLIP_H, igt_pkg::MODE_FLIP_V: begin
                    ow = sw;
                    oh = sh;
                end
                igt_pkg::MODE_ROT_CW, igt_pkg::MODE_ROT_CC: begin
                    ow = sh;
                    oh = sw;
                end
                default: begin
                    ow = 0;
                    oh = 0;
                end
            endcase
            if (xi >= ow || yi >= oh) begin
                err = 1'b1;
                return 1'b0;
            end
            case (mode)
                igt_pkg::MODE_RESIZE: begin
                    sx = (xi * sw) / ow;
                    sy = (yi * sh) / oh;
                    if (sx >= sw) sx = sw - 1;
                    if (sy >= sh) sy = sh - 1;
                end
                igt_pkg::MODE_CROP: begin
                    cx = xi + int'($signed(crop_x));
                    cy = yi + int'($signed(crop_y));
                    if (cx < 0 || cy < 0 || cx >= sw || cy >= sh) begin
                        filled = 1'b1;
                    end else begin
                        sx = cx;
                        sy = cy;
                    end
                end
                igt_pkg::MODE_FLIP_H: begin
                    sx = sw - 1 - xi;
                    sy = yi;
                end
                igt_pkg::MODE_FLIP_V: begin
                    sx = xi;
                    sy = sh - 1 - yi;
                end
                igt_pkg::MODE_ROT_CW: begin
                    sx = yi;
                    sy = sh - 1 - xi;
                end
                default: begin
                    sx = sw - 1 - yi;
                    sy = xi;
                end
            endcase
            addr = sy * igt_pkg::MAX_WIDTH + sx;
            return !filled;
        endfunction

        function void note_command(logic op, logic [igt_pkg::COORD_W-1:0] x,
                                   logic [igt_pkg::COORD_W-1:0] y, logic [31:0] pix);
            t_pixel_result r;
            int            addr;
            bit            filled, err;
            if (op == igt_pkg::OP_LOAD) begin
                frame[int'(y) * igt_pkg::MAX_WIDTH + int'(x)] = pix;
                return;
            end
            r.pix = '0;
            if (map_source(x, y, addr, filled, err) && frame.exists(addr))
                r.pix = frame[addr];
            r.zero_filled = filled;
            r.coord_error = err;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_pixel(logic [igt_pkg::OUT_W-1:0] pix, logic zf, logic ce);
            t_pixel_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing pending: pixel %h", pix));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (pix !== want.pix)
                report($sformatf("pixel_out %h, want %h", pix, want.pix));
            if (zf !== want.zero_filled)
                report($sformatf("zero_filled %b, want %b", zf, want.zero_filled));
            if (ce !== want.coord_error)
                report($sformatf("coord_error %b, want %b", ce, want.coord_error));
        endtask
    endclass

    t_frame_checker chk;
    int             quiet_cycles = 0;
    int             items_sent = 0;
    int             phase_count = 0;
    int             idle_pct = 0;

    image_geometric_transform_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_pixel_in    (i_pixel_in),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_pixel_out   (o_pixel_out),
        .o_zero_filled (o_zero_filled),
        .o_coord_error (o_coord_error)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((start && !busy) || o_valid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && o_valid)
            chk.check_pixel(o_pixel_out, o_zero_filled, o_coord_error);
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // one command transfer; start stays high so back-to-back commands need no gap
    task send_item(logic op, logic [igt_pkg::COORD_W-1:0] x,
                   logic [igt_pkg::COORD_W-1:0] y, logic [31:0] pix);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_opcode   <= op;
        i_coord_x  <= x;
        i_coord_y  <= y;
        i_pixel_in <= pix;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        chk.note_command(op, x, y, pix);
        items_sent++;
    endtask

    // a read never touches an unwritten store entry: load it first if needed
    task send_read(logic [igt_pkg::COORD_W-1:0] x, logic [igt_pkg::COORD_W-1:0] y);
        int addr;
        bit filled, err;
        if (chk.map_source(x, y, addr, filled, err) && !chk.frame.exists(addr))
            send_item(igt_pkg::OP_LOAD,
                      igt_pkg::COORD_W'(addr % igt_pkg::MAX_WIDTH),
                      igt_pkg::COORD_W'(addr / igt_pkg::MAX_WIDTH), $urandom());
        send_item(igt_pkg::OP_READ, x, y, $urandom());
    endtask

    task write_cfg(logic [igt_pkg::CIDX_W-1:0] idx, logic [igt_pkg::CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        chk.write_reg(idx, val);
    endtask

    task program_phase(logic [igt_pkg::MODE_W-1:0] mode,
                       logic [igt_pkg::CFG_W-1:0] sw, logic [igt_pkg::CFG_W-1:0] sh,
                       logic [igt_pkg::CFG_W-1:0] ow, logic [igt_pkg::CFG_W-1:0] oh,
                       logic [igt_pkg::CFG_W-1:0] cx, logic [igt_pkg::CFG_W-1:0] cy);
        start <= 1'b0;
        while (chk.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_cfg(igt_pkg::REG_MODE, igt_pkg::CFG_W'(mode));
        write_cfg(igt_pkg::REG_SRC_WIDTH, sw);
        write_cfg(igt_pkg::REG_SRC_HEIGHT, sh);
        write_cfg(igt_pkg::REG_OUT_WIDTH, ow);
        write_cfg(igt_pkg::REG_OUT_HEIGHT, oh);
        write_cfg(igt_pkg::REG_CROP_X, cx);
        write_cfg(igt_pkg::REG_CROP_Y, cy);
        i_cfg_we <= 1'b0;
        idle_pct = IDLE_PLAN[phase_count % 4];
        phase_count++;
    endtask

    function automatic logic [igt_pkg::COORD_W-1:0] rand_coord(int span);
        if ($urandom_range(99) < 80)
            return igt_pkg::COORD_W'($urandom_range(span));
        return igt_pkg::COORD_W'($urandom());
    endfunction

    // mostly small frames keep the loads cheap, with a few at and past the limits
    function automatic logic [igt_pkg::CFG_W-1:0] rand_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return igt_pkg::CFG_W'($urandom_range(16, 1));
        if (roll < 80) return igt_pkg::CFG_W'($urandom_range(256, 17));
        if (roll < 88) return igt_pkg::CFG_W'(256);
        if (roll < 94) return '0;
        return igt_pkg::CFG_W'($urandom_range(511, 257));
    endfunction

    function automatic logic [igt_pkg::CFG_W-1:0] rand_offset();
        if ($urandom_range(99) < 70)
            return igt_pkg::CFG_W'(int'($urandom_range(40)) - 20);
        return igt_pkg::CFG_W'($urandom());
    endfunction

    task run_phase(logic [igt_pkg::MODE_W-1:0] mode,
                   logic [igt_pkg::CFG_W-1:0] sw, logic [igt_pkg::CFG_W-1:0] sh,
                   logic [igt_pkg::CFG_W-1:0] ow, logic [igt_pkg::CFG_W-1:0] oh,
                   logic [igt_pkg::CFG_W-1:0] cx, logic [igt_pkg::CFG_W-1:0] cy, int n);
        int m, span;
        program_phase(mode, sw, sh, ow, oh, cx, cy);
        m = int'(sw);
        if (int'(sh) > m) m = int'(sh);
        if (int'(ow) > m) m = int'(ow);
        if (int'(oh) > m) m = int'(oh);
        span = (m > 254) ? 255 : m + 1;
        repeat (n) begin
            if ($urandom_range(99) < 25)
                send_item(igt_pkg::OP_LOAD, rand_coord(span), rand_coord(span), $urandom());
            else
                send_read(rand_coord(span), rand_coord(span));
        end
    endtask

    initial begin
        int target;
        logic [igt_pkg::MODE_W-1:0] rmode;
        chk = new();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_opcode    <= igt_pkg::OP_LOAD;
        i_coord_x   <= '0;
        i_coord_y   <= '0;
        i_pixel_in  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= igt_pkg::REG_MODE;
        i_cfg_wdata <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners and extreme pixels under the reset setting, an identity resize
        send_item(igt_pkg::OP_LOAD, 8'd0, 8'd0, 32'h0000_0000);
        send_item(igt_pkg::OP_LOAD, 8'd255, 8'd255, 32'hFFFF_FFFF);
        send_item(igt_pkg::OP_LOAD, 8'd255, 8'd0, 32'hA5A5_5A5A);
        send_item(igt_pkg::OP_LOAD, 8'd0, 8'd255, 32'h0F0F_F0F0);
        send_read(8'd0, 8'd0);
        send_read(8'd255, 8'd255);
        send_read(8'd255, 8'd0);
        send_read(8'd0, 8'd255);
        send_read(8'd128, 8'd64);
        send_item(igt_pkg::OP_LOAD, 8'd17, 8'd200, 32'h8000_0001);
        send_read(8'd17, 8'd200);

        target = items_sent + RANDOM_ITEMS;
        run_phase(igt_pkg::MODE_RESIZE, 9'd1, 9'd1, 9'd256, 9'd256, 9'd0, 9'd0, 30);
        run_phase(igt_pkg::MODE_RESIZE, 9'd256, 9'd256, 9'd1, 9'd3, 9'd0, 9'd0, 20);
        // source sizes of zero and past the store act as one and the maximum
        run_phase(igt_pkg::MODE_RESIZE, 9'd0, 9'd511, 9'd37, 9'd300, 9'd0, 9'd0, 30);
        run_phase(igt_pkg::MODE_RESIZE, 9'd5, 9'd7, 9'd0, 9'd0, 9'd0, 9'd0, 20);
        run_phase(igt_pkg::MODE_CROP, 9'd256, 9'd256, 9'd256, 9'd256, 9'h100, 9'h100, 30);
        run_phase(igt_pkg::MODE_CROP, 9'd256, 9'd256, 9'd256, 9'd256, 9'h0FF, 9'h0FF, 30);
        run_phase(igt_pkg::MODE_CROP, 9'd12, 9'd9, 9'd20, 9'd16, 9'h1FB, 9'd3, 40);
        run_phase(igt_pkg::MODE_FLIP_H, 9'd256, 9'd1, 9'd0, 9'd0, 9'd0, 9'd0, 30);
        run_phase(igt_pkg::MODE_FLIP_V, 9'd1, 9'd256, 9'd0, 9'd0, 9'd0, 9'd0, 30);
        run_phase(igt_pkg::MODE_ROT_CW, 9'd256, 9'd256, 9'd4, 9'd4, 9'd0, 9'd0, 30);
        run_phase(igt_pkg::MODE_ROT_CC, 9'd0, 9'd511, 9'd4, 9'd4, 9'd0, 9'd0, 30);
        run_phase(MODE_UNUSED_A, 9'd8, 9'd8, 9'd8, 9'd8, 9'd0, 9'd0, 15);
        run_phase(MODE_UNUSED_B, 9'd8, 9'd8, 9'd8, 9'd8, 9'd0, 9'd0, 15);

        while (items_sent < target) begin
            if ($urandom_range(99) < 90)
                rmode = igt_pkg::MODE_W'($urandom_range(igt_pkg::MODE_ROT_CC));
            else
                rmode = igt_pkg::MODE_W'($urandom_range(MODE_UNUSED_B, MODE_UNUSED_A));
            run_phase(rmode, rand_size(), rand_size(), rand_size(), rand_size(),
                      rand_offset(), rand_offset(), $urandom_range(60, 20));
        end

        start <= 1'b0;
        while (chk.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d commands in %0d register settings, %0d read results checked",
                 items_sent, phase_count, chk.checked);
        $display("all six modes, unused modes, zero and oversized frames, crop edges");
        if (chk.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
sv/igt_pkg.sv
sv/image_geometric_transform_core.sv
sv/igt_checker.sv
test/tb_top.sv
